// ----- sv/tlvdp_pkg.sv -----
`default_nettype none

package tlvdp_pkg;

  localparam logic [7:0] MAGIC_VALUE   = 8'd95;
  localparam logic [7:0] VERSION_VALUE = 8'd1;
  localparam logic [7:0] FIXED_PART    = 8'd26;
  localparam logic [7:0] HASH_BYTES    = 8'd16;
  localparam logic [7:0] ID_BYTES      = 8'd8;

  localparam logic [7:0] TYPE_PAD1      = 8'd0;
  localparam logic [7:0] TYPE_PADN      = 8'd1;
  localparam logic [7:0] TYPE_REQ_ALL   = 8'd2;
  localparam logic [7:0] TYPE_PEER      = 8'd3;
  localparam logic [7:0] TYPE_NET_HASH  = 8'd4;
  localparam logic [7:0] TYPE_REQ_STATE = 8'd5;
  localparam logic [7:0] TYPE_NODE_HASH = 8'd6;
  localparam logic [7:0] TYPE_NODE_REQ  = 8'd7;
  localparam logic [7:0] TYPE_NODE_DATA = 8'd8;
  localparam logic [7:0] TYPE_WARNING   = 8'd9;

  localparam logic [1:0] KIND_TLV     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_MAGIC     = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_BODY_LONG = 4'd3;
  localparam logic [3:0] ST_OVERRUN   = 4'd4;
  localparam logic [3:0] ST_PADN      = 4'd5;
  localparam logic [3:0] ST_LENGTH    = 4'd6;
  localparam logic [3:0] ST_DATA_LONG = 4'd7;
  localparam logic [3:0] ST_TRUNCATED = 4'd8;

  localparam logic [1:0] CFG_MAX_BODY = 2'd0;
  localparam logic [1:0] CFG_MAX_DATA = 2'd1;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_TYPE   = 6'b000010,
    PH_LENGTH = 6'b000100,
    PH_VALUE  = 6'b001000,
    PH_TAIL   = 6'b010000,
    PH_FAULT  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_datagram;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  tlv_type;
    logic [63:0] node_id;
    logic [15:0] sequence_number;
    logic [63:0] hash_high;
    logic [63:0] hash_low;
    logic [15:0] peer_port;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_length;
    logic [3:0]  status;
    logic        last_result;
  } out_req_t;

  function automatic logic [7:0] fixed_need(input logic [7:0] t);
    logic [7:0] r;
    begin
      case (t)
        TYPE_PEER:      r = HASH_BYTES + 8'd2;
        TYPE_NET_HASH:  r = HASH_BYTES;
        TYPE_NODE_HASH: r = FIXED_PART;
        TYPE_NODE_REQ:  r = ID_BYTES;
        TYPE_NODE_DATA: r = FIXED_PART;
        default:        r = 8'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] payload_size(input logic [7:0] t, input logic [7:0] len);
    logic [7:0] r;
    begin
      r = 8'd0;
      if (t == TYPE_NODE_DATA && len >= FIXED_PART) begin
        r = len - FIXED_PART;
      end else if (t == TYPE_WARNING) begin
        r = len;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/tlv_datagram_parser_unit.sv -----
// Byte-serial datagram parser: 4-byte header (magic, version, body length)
// followed by a body of TLVs.
// Input channel: one datagram byte per request (in_valid_i / in_stall_o),
// end_of_datagram set on the final byte. Output channel: records, payload
// bytes and one status result per datagram (out_valid_o / out_stall_i).
// Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
// the body length limit, index 1 the type 8 payload limit; write only idle.
// Each byte is parsed in the cycle it is accepted and its results (at most
// two: one record plus the status on the last byte) are written into a
// 4-entry output queue, so a result is in the queue in the cycle after its byte.
// Throughput is one byte per cycle while the consumer keeps up; the queue
// drains one result per cycle while out_stall_i is low, and input stalls
// when fewer than two queue slots are free. A stalled output holds its
// head result unchanged. Reset empties the queue, returns the parser to the
// header phase and loads the limits with 1020 and 192.
`default_nettype none

module tlv_datagram_parser_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire tlvdp_pkg::in_req_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output tlvdp_pkg::out_req_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  tlvdp_pkg::phase_e phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] body_end_q, body_end_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  vidx_q, vidx_d;
  logic [63:0] id_q, id_d;
  logic [15:0] seq_q, seq_d;
  logic [63:0] hh_q, hh_d;
  logic [63:0] hl_q, hl_d;
  logic [15:0] port_q, port_d;
  logic [3:0]  err_q, err_d;
  logic [15:0] max_body_q;
  logic [7:0]  max_data_q;

  tlvdp_pkg::out_req_t queue_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   count_q;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic [15:0] pos_inc, left;
  logic [7:0]  need, k1;
  logic        rec_valid, rec_payload, stat_valid;
  tlvdp_pkg::out_req_t rec, stat;
  logic [1:0]  n_push;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = count_q > (QAw+1)'(QDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = queue_q[rd_ptr_q];
  assign cfg_ready_o = 1'b1;

  assign b       = in_data_i.byte_value;
  assign pos_inc = pos_q + 16'd1;
  assign left    = body_end_q - pos_inc;
  assign need    = tlvdp_pkg::fixed_need(type_q);
  assign k1      = vidx_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    body_end_d = body_end_q;
    type_d     = type_q;
    len_d      = len_q;
    vidx_d     = vidx_q;
    id_d       = id_q;
    seq_d      = seq_q;
    hh_d       = hh_q;
    hl_d       = hl_q;
    port_d     = port_q;
    err_d      = err_q;
    rec_valid  = 1'b0;
    rec_payload = 1'b0;
    stat_valid = 1'b0;
    rec        = '0;
    stat       = '0;
    if (in_fire) begin
      case (phase_q)
        tlvdp_pkg::PH_HEADER: begin
          case (pos_q[1:0])
            2'd0: begin
              if (b != tlvdp_pkg::MAGIC_VALUE) begin
                err_d = tlvdp_pkg::ST_MAGIC;
                phase_d = tlvdp_pkg::PH_FAULT;
              end
            end
            2'd1: begin
              if (b != tlvdp_pkg::VERSION_VALUE) begin
                err_d = tlvdp_pkg::ST_VERSION;
                phase_d = tlvdp_pkg::PH_FAULT;
              end
            end
            2'd2: body_end_d = {b, 8'd0};
            default: begin
              body_end_d = {body_end_q[15:8], b};
              if ({body_end_q[15:8], b} > max_body_q) begin
                err_d = tlvdp_pkg::ST_BODY_LONG;
                phase_d = tlvdp_pkg::PH_FAULT;
              end else begin
                phase_d = (body_end_q[15:8] == 8'd0 && b == 8'd0) ?
                          tlvdp_pkg::PH_TAIL : tlvdp_pkg::PH_TYPE;
              end
            end
          endcase
          pos_d = (phase_d == tlvdp_pkg::PH_HEADER) ? pos_inc : 16'd0;
        end
        tlvdp_pkg::PH_TYPE: begin
          pos_d = pos_inc;
          if (b == tlvdp_pkg::TYPE_PAD1) begin
            phase_d = (pos_inc == body_end_q) ? tlvdp_pkg::PH_TAIL : tlvdp_pkg::PH_TYPE;
          end else if (pos_inc == body_end_q) begin
            err_d = tlvdp_pkg::ST_OVERRUN;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else begin
            type_d  = b;
            len_d   = 8'd0;
            vidx_d  = 8'd0;
            id_d    = '0;
            seq_d   = '0;
            hh_d    = '0;
            hl_d    = '0;
            port_d  = '0;
            phase_d = tlvdp_pkg::PH_LENGTH;
          end
        end
        tlvdp_pkg::PH_LENGTH: begin
          pos_d = pos_inc;
          len_d = b;
          if ({8'd0, b} > left) begin
            err_d = tlvdp_pkg::ST_OVERRUN;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else if ((type_q == tlvdp_pkg::TYPE_REQ_ALL ||
                         type_q == tlvdp_pkg::TYPE_REQ_STATE) && b != 8'd0) begin
            err_d = tlvdp_pkg::ST_LENGTH;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else if (b < need) begin
            err_d = tlvdp_pkg::ST_LENGTH;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else if (type_q == tlvdp_pkg::TYPE_NODE_DATA &&
                       (b - tlvdp_pkg::FIXED_PART) > max_data_q) begin
            err_d = tlvdp_pkg::ST_DATA_LONG;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else if (b == 8'd0) begin
            rec_valid = type_q >= tlvdp_pkg::TYPE_PADN && type_q <= tlvdp_pkg::TYPE_WARNING;
            phase_d = (pos_inc == body_end_q) ? tlvdp_pkg::PH_TAIL : tlvdp_pkg::PH_TYPE;
          end else begin
            rec_valid = type_q == tlvdp_pkg::TYPE_WARNING;
            vidx_d = 8'd0;
            phase_d = tlvdp_pkg::PH_VALUE;
          end
        end
        tlvdp_pkg::PH_VALUE: begin
          pos_d = pos_inc;
          if (type_q == tlvdp_pkg::TYPE_PADN && b != 8'd0) begin
            err_d = tlvdp_pkg::ST_PADN;
            phase_d = tlvdp_pkg::PH_FAULT;
          end else begin
            case (type_q)
              tlvdp_pkg::TYPE_PEER, tlvdp_pkg::TYPE_NET_HASH: begin
                if (vidx_q < 8'd8) begin
                  hh_d = {hh_q[55:0], b};
                end else if (vidx_q < 8'd16) begin
                  hl_d = {hl_q[55:0], b};
                end else if (vidx_q < 8'd18 && type_q == tlvdp_pkg::TYPE_PEER) begin
                  port_d = {port_q[7:0], b};
                end
              end
              tlvdp_pkg::TYPE_NODE_HASH, tlvdp_pkg::TYPE_NODE_DATA: begin
                if (vidx_q < 8'd8) begin
                  id_d = {id_q[55:0], b};
                end else if (vidx_q < 8'd10) begin
                  seq_d = {seq_q[7:0], b};
                end else if (vidx_q < 8'd18) begin
                  hh_d = {hh_q[55:0], b};
                end else if (vidx_q < tlvdp_pkg::FIXED_PART) begin
                  hl_d = {hl_q[55:0], b};
                end else if (type_q == tlvdp_pkg::TYPE_NODE_DATA) begin
                  rec_valid = 1'b1;
                  rec_payload = 1'b1;
                end
              end
              tlvdp_pkg::TYPE_NODE_REQ: begin
                if (vidx_q < 8'd8) begin
                  id_d = {id_q[55:0], b};
                end
              end
              tlvdp_pkg::TYPE_WARNING: begin
                rec_valid = 1'b1;
                rec_payload = 1'b1;
              end
              default: ;
            endcase
            vidx_d = k1;
            if (type_q == tlvdp_pkg::TYPE_NODE_DATA && k1 == tlvdp_pkg::FIXED_PART) begin
              rec_valid = 1'b1;
            end
            if (k1 == len_q) begin
              if (type_q >= tlvdp_pkg::TYPE_PADN && type_q <= tlvdp_pkg::TYPE_NODE_REQ) begin
                rec_valid = 1'b1;
              end
              phase_d = (pos_inc == body_end_q) ? tlvdp_pkg::PH_TAIL : tlvdp_pkg::PH_TYPE;
            end
          end
        end
        default: ;
      endcase

      rec.record_kind    = rec_payload ? tlvdp_pkg::KIND_PAYLOAD : tlvdp_pkg::KIND_TLV;
      rec.tlv_type       = type_d;
      rec.node_id        = rec_payload ? 64'd0 : id_d;
      rec.sequence_number = rec_payload ? 16'd0 : seq_d;
      rec.hash_high      = rec_payload ? 64'd0 : hh_d;
      rec.hash_low       = rec_payload ? 64'd0 : hl_d;
      rec.peer_port      = rec_payload ? 16'd0 : port_d;
      rec.payload_byte   = rec_payload ? b : 8'd0;
      rec.payload_length = tlvdp_pkg::payload_size(type_d, len_d);

      if (in_data_i.end_of_datagram) begin
        stat_valid = 1'b1;
        stat.record_kind = tlvdp_pkg::KIND_STATUS;
        stat.last_result = 1'b1;
        if (err_d != tlvdp_pkg::ST_OK) begin
          stat.status = err_d;
        end else begin
          stat.status = (phase_d == tlvdp_pkg::PH_TAIL) ?
                        tlvdp_pkg::ST_OK : tlvdp_pkg::ST_TRUNCATED;
        end
        phase_d    = tlvdp_pkg::PH_HEADER;
        pos_d      = '0;
        body_end_d = '0;
        type_d     = '0;
        len_d      = '0;
        vidx_d     = '0;
        id_d       = '0;
        seq_d      = '0;
        hh_d       = '0;
        hl_d       = '0;
        port_d     = '0;
        err_d      = tlvdp_pkg::ST_OK;
      end
    end
  end

  assign n_push = {1'b0, rec_valid} + {1'b0, stat_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tlvdp_pkg::PH_HEADER;
      pos_q      <= '0;
      body_end_q <= '0;
      type_q     <= '0;
      len_q      <= '0;
      vidx_q     <= '0;
      id_q       <= '0;
      seq_q      <= '0;
      hh_q       <= '0;
      hl_q       <= '0;
      port_q     <= '0;
      err_q      <= tlvdp_pkg::ST_OK;
      max_body_q <= 16'd1020;
      max_data_q <= 8'd192;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      body_end_q <= body_end_d;
      type_q     <= type_d;
      len_q      <= len_d;
      vidx_q     <= vidx_d;
      id_q       <= id_d;
      seq_q      <= seq_d;
      hh_q       <= hh_d;
      hl_q       <= hl_d;
      port_q     <= port_d;
      err_q      <= err_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tlvdp_pkg::CFG_MAX_BODY) begin
          max_body_q <= cfg_data_i;
        end else if (cfg_index_i == tlvdp_pkg::CFG_MAX_DATA) begin
          max_data_q <= cfg_data_i[7:0];
        end
      end
      wr_ptr_q <= wr_ptr_q + QAw'(n_push);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QAw'(1);
      end
      count_q <= count_q + (QAw+1)'(n_push) - (QAw+1)'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid) begin
      queue_q[wr_ptr_q] <= rec;
    end
    if (stat_valid) begin
      queue_q[wr_ptr_q + QAw'(rec_valid)] <= stat;
    end
  end

endmodule

`default_nettype wire
